// File: hdl/cmu_pkg.sv
// Shared types, codes and helper functions for the clause mask unit propagation block.
package cmu_pkg;

  // Field widths of the stream words.
  localparam int OP_W   = 2;
  localparam int IDX_W  = 12;
  localparam int POS_W  = 5;
  localparam int MASK_W = 32;
  localparam int KIND_W = 2;

  // Operation codes carried in the input tuser.
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTORE = 2'd2;
  localparam logic [OP_W-1:0] OP_TEST    = 2'd3;

  // Result kinds carried in the output tuser.
  localparam logic [KIND_W-1:0] KIND_UNIT     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CONFLICT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TEST     = 2'd2;

  // Result queue depth and its pointer and count widths.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  // Operation after the read-modify-write step, on its way to result encoding.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [MASK_W-1:0] mask;
    logic              two_before;
  } stage_t;

  // One result word.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic [POS_W-1:0]  pos;
    logic              unit;
  } result_t;

  // True when exactly one bit of the mask is set.
  function automatic logic is_single(input logic [MASK_W-1:0] v);
    return (v != '0) && ((v & (v - 1'b1)) == '0);
  endfunction

  // Position of the lowest set bit, zero for an empty mask.
  function automatic logic [POS_W-1:0] lowest_set(input logic [MASK_W-1:0] v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        p = POS_W'(i);
      end
    end
    return p;
  endfunction

endpackage

// File: hdl/clause_mask_unit_propagation_top.sv
// Top level of the clause mask unit propagation block.
// Each input word is one operation on one clause mask held in an on-chip table
// of min(CLAUSE_COUNT, 4096) entries. The block takes one word per cycle for as
// long as the output side keeps taking results; a result passes the first and
// second stages, enters the output queue and is offered on the master side
// once it is written there. The rate is set by the read-modify-write loop on the
// clause memory, whose registered read is covered by forwarding the
// previous cycle's write, and by the four-entry result queue, which bounds the
// operations in flight when the output stalls. Masks are not cleared at reset:
// a clause must be loaded before any other operation addresses it. Words whose
// clause index is at or beyond CLAUSE_COUNT are accepted and dropped.
module clause_mask_unit_propagation_top #(
  parameter int CLAUSE_COUNT = 4096,
  parameter int MAX_LITERALS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, low bit up: clause_index[11:0], literal_position[16:12],
  // mask_value[48:17], zero fill[55:49]
  input  logic [55:0] s_tdata,
  // s_tuser: opcode[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, low bit up: clause_index_out[11:0], implied_position[16:12],
  // is_unit[17], zero fill[23:18]
  output logic [23:0] m_tdata,
  // m_tuser: kind[1:0]
  output logic [1:0]  m_tuser
);

  logic                             in_fire;
  logic                             s1_busy;
  logic                             s2_valid;
  cmu_pkg::stage_t                  s2;
  logic                             push;
  cmu_pkg::result_t                 res;
  cmu_pkg::result_t                 head;
  logic [cmu_pkg::OUT_CNT_W-1:0]    count;
  logic [cmu_pkg::OUT_CNT_W-1:0]    used;

  // Every operation in flight holds a queue slot in reserve.
  assign used     = count + cmu_pkg::OUT_CNT_W'(s1_busy) + cmu_pkg::OUT_CNT_W'(s2_valid);
  assign s_tready = (used < cmu_pkg::OUT_CNT_W'(cmu_pkg::OUT_DEPTH));
  assign in_fire  = s_tvalid && s_tready;

  cmu_table #(
    .CLAUSE_COUNT (CLAUSE_COUNT),
    .MAX_LITERALS (MAX_LITERALS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_fire),
    .in_op    (s_tuser),
    .in_idx   (s_tdata[11:0]),
    .in_pos   (s_tdata[16:12]),
    .in_mask  (s_tdata[48:17]),
    .s1_busy  (s1_busy),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  cmu_result u_result (
    .s2_valid (s2_valid),
    .s2       (s2),
    .push     (push),
    .res      (res)
  );

  cmu_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (res),
    .pop       (m_tready),
    .not_empty (m_tvalid),
    .dout      (head),
    .count     (count)
  );

  // Output word packing.
  assign m_tuser = head.kind;
  assign m_tdata = {6'd0, head.unit, head.pos, head.idx};

endmodule

// File: hdl/cmu_table.sv
// Clause mask memory with read-modify-write and one-deep write forwarding.
module cmu_table #(
  parameter int CLAUSE_COUNT = 4096,
  parameter int MAX_LITERALS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [cmu_pkg::OP_W-1:0]    in_op,
  input  logic [cmu_pkg::IDX_W-1:0]   in_idx,
  input  logic [cmu_pkg::POS_W-1:0]   in_pos,
  input  logic [cmu_pkg::MASK_W-1:0]  in_mask,
  output logic                        s1_busy,
  output logic                        s2_valid,
  output cmu_pkg::stage_t             s2
);

  localparam int FULL_DEPTH = 1 << cmu_pkg::IDX_W;
  localparam int DEPTH  = (CLAUSE_COUNT < FULL_DEPTH) ? CLAUSE_COUNT : FULL_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LANES  = (MAX_LITERALS < cmu_pkg::MASK_W) ? MAX_LITERALS : cmu_pkg::MASK_W;
  localparam logic [cmu_pkg::MASK_W-1:0] LANE_MASK =
    cmu_pkg::MASK_W'((64'd1 << LANES) - 64'd1);

  logic [LANES-1:0] mem [DEPTH];
  logic [LANES-1:0] rdata;

  logic                        s1_valid;
  logic [cmu_pkg::OP_W-1:0]    s1_op;
  logic [cmu_pkg::IDX_W-1:0]   s1_idx;
  logic [cmu_pkg::MASK_W-1:0]  s1_bit;
  logic [cmu_pkg::MASK_W-1:0]  s1_load;

  logic                        fwd_valid;
  logic [ADDR_W-1:0]           fwd_addr;
  logic [LANES-1:0]            fwd_data;

  logic                        in_range;
  logic                        pos_ok;
  logic [cmu_pkg::MASK_W-1:0]  in_bit;
  logic [ADDR_W-1:0]           s1_addr;
  logic [cmu_pkg::MASK_W-1:0]  old_mask;
  logic [cmu_pkg::MASK_W-1:0]  new_mask;
  logic                        we;

  // Items addressing a clause beyond the table are dropped here.
  assign in_range = (32'(in_idx) < CLAUSE_COUNT);
  assign pos_ok   = (32'(in_pos) < MAX_LITERALS);
  assign in_bit   = pos_ok ? (cmu_pkg::MASK_W'(1) << in_pos) : '0;
  assign s1_addr  = s1_idx[ADDR_W-1:0];
  assign s1_busy  = s1_valid;

  // Memory read port, issued in the cycle the word is accepted.
  always_ff @(posedge clk) begin
    rdata <= mem[in_idx[ADDR_W-1:0]];
  end

  // Memory write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[s1_addr] <= new_mask[LANES-1:0];
    end
  end

  // First stage: operation waiting for its read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid && in_range;
    end
    s1_op   <= in_op;
    s1_idx  <= in_idx;
    s1_bit  <= in_bit;
    s1_load <= in_mask & LANE_MASK;
  end

  // The write of the previous cycle is not yet visible at the read port.
  always_comb begin
    if (fwd_valid && (fwd_addr == s1_addr)) begin
      old_mask = cmu_pkg::MASK_W'(fwd_data);
    end else begin
      old_mask = cmu_pkg::MASK_W'(rdata);
    end
  end

  // Modify step for each operation.
  always_comb begin
    new_mask = old_mask;
    we       = 1'b0;
    case (s1_op)
      cmu_pkg::OP_LOAD: begin
        new_mask = s1_load;
        we       = s1_valid;
      end
      cmu_pkg::OP_CLEAR: begin
        new_mask = old_mask & ~s1_bit;
        we       = s1_valid;
      end
      cmu_pkg::OP_RESTORE: begin
        new_mask = (old_mask | s1_bit) & LANE_MASK;
        we       = s1_valid;
      end
      cmu_pkg::OP_TEST: begin
        new_mask = old_mask;
      end
      default: begin
        new_mask = old_mask;
      end
    endcase
  end

  // Forwarding register and second stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      s2_valid  <= 1'b0;
    end else begin
      fwd_valid <= we;
      s2_valid  <= s1_valid;
    end
    fwd_addr      <= s1_addr;
    fwd_data      <= new_mask[LANES-1:0];
    s2.op         <= s1_op;
    s2.idx        <= s1_idx;
    s2.mask       <= new_mask;
    s2.two_before <= cmu_pkg::is_single(old_mask & (old_mask - 1'b1));
  end

endmodule

// File: hdl/cmu_result.sv
// Result encoding from the updated clause mask.
module cmu_result (
  input  logic             s2_valid,
  input  cmu_pkg::stage_t  s2,
  output logic             push,
  output cmu_pkg::result_t res
);

  logic                       empty;
  logic                       single;
  logic [cmu_pkg::POS_W-1:0]  low;

  assign empty  = (s2.mask == '0);
  assign single = cmu_pkg::is_single(s2.mask);
  assign low    = cmu_pkg::lowest_set(s2.mask);

  // Decide whether the operation reports anything, and what.
  always_comb begin
    push     = 1'b0;
    res.kind = cmu_pkg::KIND_UNIT;
    res.idx  = s2.idx;
    res.pos  = low;
    res.unit = 1'b0;
    case (s2.op)
      cmu_pkg::OP_LOAD: begin
        if (empty) begin
          res.kind = cmu_pkg::KIND_CONFLICT;
          push     = s2_valid;
        end else if (single) begin
          push = s2_valid;
        end
      end
      cmu_pkg::OP_CLEAR: begin
        if (empty) begin
          res.kind = cmu_pkg::KIND_CONFLICT;
          push     = s2_valid;
        end else if (s2.two_before) begin
          push = s2_valid;
        end
      end
      cmu_pkg::OP_RESTORE: begin
        push = 1'b0;
      end
      cmu_pkg::OP_TEST: begin
        res.kind = cmu_pkg::KIND_TEST;
        res.unit = single;
        res.pos  = single ? low : '0;
        push     = s2_valid;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

// File: hdl/cmu_out_fifo.sv
// Small result queue that decouples the pipeline from the output stall.
module cmu_out_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  cmu_pkg::result_t                din,
  input  logic                            pop,
  output logic                            not_empty,
  output cmu_pkg::result_t                dout,
  output logic [cmu_pkg::OUT_CNT_W-1:0]   count
);

  cmu_pkg::result_t               slots [cmu_pkg::OUT_DEPTH];
  logic [cmu_pkg::OUT_PTR_W-1:0]  wr_ptr;
  logic [cmu_pkg::OUT_PTR_W-1:0]  rd_ptr;
  logic                           do_pop;

  assign not_empty = (count != '0);
  assign dout      = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  // Slot storage; the upstream credit check keeps a push off a full queue.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/cmu_checker.sv
// Port-level checks for the clause mask unit propagation block, bound to its top level.
module cmu_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // No result is offered right after reset.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered after reset");

  // Only the three defined result kinds appear.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == cmu_pkg::KIND_UNIT) || (m_tuser == cmu_pkg::KIND_CONFLICT) ||
                 (m_tuser == cmu_pkg::KIND_TEST))
    else $error("undefined result kind");

  // A conflict carries neither a position nor the unit flag.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == cmu_pkg::KIND_CONFLICT)) |-> (m_tdata[17:12] == 6'd0))
    else $error("conflict with position or unit flag");

  // The unit flag belongs to test replies alone.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[17]) |-> (m_tuser == cmu_pkg::KIND_TEST))
    else $error("unit flag outside a test reply");

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result word changed");

endmodule

bind clause_mask_unit_propagation_top cmu_checker u_cmu_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
